// ----- rtl/lr_pkg.sv -----
// lr_pkg: coordinate width, request/result payload types and rasterizer state
// for the line rasterizer. No dependencies.
`default_nettype none

package lr_pkg;

	localparam int COORD_BITS = 12;
	// err_term, inc_straight and inc_diagonal widths follow from COORD_BITS
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int INC_S_BITS = COORD_BITS + 2;
	localparam int INC_D_BITS = COORD_BITS + 3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_NEXT  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   req_type;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} lr_req_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last;
		logic   valid_res;
	} lr_res_t;

	typedef struct packed {
		coord_t                       cur_x;
		coord_t                       cur_y;
		coord_t                       major_end;
		logic signed [ERR_BITS-1:0]   err_term;
		logic [INC_S_BITS-1:0]        inc_straight;
		logic signed [INC_D_BITS-1:0] inc_diagonal;
		logic                         minor_down;
		logic                         steep;
		logic                         active;
	} lr_state_t;

endpackage

`default_nettype wire

// ----- rtl/line_rasterizer.sv -----
// line_rasterizer: top level, input register, rasterizer state and result register.
// Depends on lr_pkg and lr_step.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------
//   request | req_valid/req_stall  | req (lr_req_t)
//   result  | res_valid/res_stall  | res (lr_res_t)
//
// One transaction per clock sustained while the result is not stalled; a taken request
// loads the input register, and the result register loads from it once the slot is free.
// The whole setup or midpoint step sits between those two registers.
// arst_n clears the rasterizer state (no line active) and both valid flags.
// A stalled result holds the input register; req_stall rises only then.
`default_nettype none

module line_rasterizer
	import lr_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     req_valid,
	output logic    req_stall,
	input  lr_req_t req,
	output logic    res_valid,
	input  wire     res_stall,
	output lr_res_t res
);

	lr_req_t   req_s1;
	logic      vld_s1;
	lr_res_t   res_q;
	logic      res_vld_q;
	lr_state_t state_q;
	lr_state_t state_nxt;
	lr_res_t   step_res;
	logic      adv, take;

	lr_step u_step (
		.st  (state_q),
		.req (req_s1),
		.nxt (state_nxt),
		.res (step_res)
	);

	assign adv       = vld_s1 && (!res_vld_q || !res_stall);
	assign req_stall = vld_s1 && !adv;
	assign take      = req_valid && !req_stall;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			state_q   <= '0;
		end else begin
			if (take)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;
			if (adv) begin
				res_vld_q <= 1'b1;
				state_q   <= state_nxt;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req;
		if (adv)
			res_q <= step_res;
	end

endmodule

`default_nettype wire

// ----- rtl/lr_step.sv -----
// lr_step: combinational line setup and one midpoint step.
// Produces the next rasterizer state and the result for one request. Uses lr_pkg.
`default_nettype none

module lr_step
	import lr_pkg::*;
(
	input  lr_state_t st,
	input  lr_req_t   req,
	output lr_state_t nxt,
	output lr_res_t   res
);

	coord_t                     x0, y0, x1, y1;
	coord_t                     fx0, fy0, fx1, fy1;
	logic signed [COORD_BITS:0] dx_s, dy_s;
	logic [COORD_BITS:0]        dx_abs, dy_abs, dmaj, dmin;
	logic signed [ERR_BITS-1:0] dmaj_e, dmin_e, inc_d_full;
	logic signed [ERR_BITS-1:0] inc_d_e, inc_s_e;
	logic                       steep_n, keep, diag, fin;
	coord_t                     major;
	lr_state_t                  cand;

	always_comb begin
		x0 = req.x_start;
		y0 = req.y_start;
		x1 = req.x_end;
		y1 = req.y_end;
		dx_s = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
		dy_s = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
		dx_abs = dx_s[COORD_BITS] ? unsigned'(-dx_s) : unsigned'(dx_s);
		dy_abs = dy_s[COORD_BITS] ? unsigned'(-dy_s) : unsigned'(dy_s);
		steep_n = dx_abs < dy_abs;
		keep = steep_n ? (y0 < y1) : (x0 < x1);
		// major axis must increase from first to last pixel
		fx0 = keep ? x0 : x1;
		fy0 = keep ? y0 : y1;
		fx1 = keep ? x1 : x0;
		fy1 = keep ? y1 : y0;
		dmaj = steep_n ? dy_abs : dx_abs;
		dmin = steep_n ? dx_abs : dy_abs;
		dmaj_e = ERR_BITS'(dmaj);
		dmin_e = ERR_BITS'(dmin);
		inc_d_full = (dmin_e - dmaj_e) <<< 1;

		inc_d_e = ERR_BITS'(st.inc_diagonal);
		inc_s_e = ERR_BITS'(st.inc_straight);
		// shallow lines go diagonal on err >= 0, steep ones only on err > 0
		diag = st.steep ? (!st.err_term[ERR_BITS-1] && (st.err_term != '0))
		                : !st.err_term[ERR_BITS-1];

		cand = st;
		if (req.req_type == REQ_START) begin
			cand.cur_x        = fx0;
			cand.cur_y        = fy0;
			cand.steep        = steep_n;
			cand.major_end    = steep_n ? fy1 : fx1;
			cand.minor_down   = steep_n ? (fx1 < fx0) : (fy1 < fy0);
			cand.err_term     = (dmin_e <<< 1) - dmaj_e;
			cand.inc_straight = {dmin, 1'b0};
			cand.inc_diagonal = INC_D_BITS'(inc_d_full);
		end else begin
			cand.err_term = st.err_term + (diag ? inc_d_e : inc_s_e);
			if (st.steep) begin
				cand.cur_y = st.cur_y + COORD_BITS'(1);
				if (diag)
					cand.cur_x = st.minor_down ? st.cur_x - COORD_BITS'(1)
					                           : st.cur_x + COORD_BITS'(1);
			end else begin
				cand.cur_x = st.cur_x + COORD_BITS'(1);
				if (diag)
					cand.cur_y = st.minor_down ? st.cur_y - COORD_BITS'(1)
					                           : st.cur_y + COORD_BITS'(1);
			end
		end

		major = cand.steep ? cand.cur_y : cand.cur_x;
		fin = major >= cand.major_end;
		cand.active = !fin;

		if (req.req_type == REQ_NEXT && !st.active) begin
			nxt = st;
			res = '0;
		end else begin
			nxt = cand;
			res.pixel_x   = cand.cur_x;
			res.pixel_y   = cand.cur_y;
			res.last      = fin;
			res.valid_res = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lr_checker.sv -----
// lr_checker: port-level assertions for line_rasterizer, bound to the top level.
// Depends on lr_pkg.
`default_nettype none

module lr_checker
	import lr_pkg::*;
(
	input wire     clk,
	input wire     arst_n,
	input wire     req_valid,
	input wire     req_stall,
	input lr_req_t req,
	input wire     res_valid,
	input wire     res_stall,
	input lr_res_t res
);

	// a stalled result transaction holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// requests are only held back by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled with empty result slot");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> res.valid_res)
		else $error("last flag on an empty result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.valid_res |-> res.pixel_x == '0 && res.pixel_y == '0)
		else $error("empty result carries pixel data");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

`default_nettype wire

// ----- test/tb_line_rasterizer.sv -----
// tb_line_rasterizer: self-checking bench for the midpoint line rasterizer.
// Depends on lr_pkg and line_rasterizer; predicts every result, checks it in order.
`default_nettype none

module tb_line_rasterizer;
	import lr_pkg::*;

	localparam int N_ITEMS    = 1450;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_LEN   = 300;
	localparam int CMIN       = -(1 << (COORD_BITS - 1));
	localparam int CMAX       = (1 << (COORD_BITS - 1)) - 1;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic    clk;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	lr_req_t req       = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	lr_res_t res;

	line_rasterizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	lr_req_t pend_reqs[$];
	lr_res_t pixel_q[$];
	int      errs      = 0;
	int      res_seen  = 0;
	int      idle_cyc  = 0;
	logic    req_taken = 1'b0;

	// rasterizer state as predicted
	int cur_x = 0, cur_y = 0, maj_end = 0, err = 0, inc_s = 0, inc_d = 0;
	bit minor_dn = 0, steep = 0, line_on = 0;

	function automatic int iabs(int a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic lr_res_t raster_step(lr_req_t r);
		int      x0, y0, x1, y1, dx, dy, t, stepv;
		bit      diag, fin;
		lr_res_t o;
		o = '0;
		if (r.req_type == REQ_START) begin
			x0 = int'(r.x_start);
			y0 = int'(r.y_start);
			x1 = int'(r.x_end);
			y1 = int'(r.y_end);
			dx = iabs(x1 - x0);
			dy = iabs(y1 - y0);
			steep = (dx < dy);
			// major axis must increase from first to last pixel
			if (!(steep ? (y0 < y1) : (x0 < x1))) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			cur_x = x0;
			cur_y = y0;
			if (!steep) begin
				maj_end  = x1;
				minor_dn = (y1 < y0);
				err      = 2 * dy - dx;
				inc_s    = 2 * dy;
				inc_d    = 2 * (dy - dx);
			end else begin
				maj_end  = y1;
				minor_dn = (x1 < x0);
				err      = 2 * dx - dy;
				inc_s    = 2 * dx;
				inc_d    = 2 * (dx - dy);
			end
		end else begin
			if (!line_on)
				return o;
			diag  = steep ? (err > 0) : (err >= 0);
			stepv = minor_dn ? -1 : 1;
			if (diag) begin
				err += inc_d;
				if (steep)
					cur_x += stepv;
				else
					cur_y += stepv;
			end else begin
				err += inc_s;
			end
			if (steep)
				cur_y += 1;
			else
				cur_x += 1;
		end
		fin         = ((steep ? cur_y : cur_x) >= maj_end);
		o.pixel_x   = coord_t'(cur_x);
		o.pixel_y   = coord_t'(cur_y);
		o.last      = fin;
		o.valid_res = 1'b1;
		line_on     = !fin;
		return o;
	endfunction

	function automatic int clip_coord(int v);
		return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
	endfunction

	task automatic queue_start(int x0, int y0, int x1, int y1);
		lr_req_t r;
		r.req_type = REQ_START;
		r.x_start  = coord_t'(x0);
		r.y_start  = coord_t'(y0);
		r.x_end    = coord_t'(x1);
		r.y_end    = coord_t'(y1);
		pend_reqs.push_back(r);
	endtask

	// coordinates of a next request are don't-care, so fill them with noise
	task automatic queue_next();
		lr_req_t r;
		r.req_type = REQ_NEXT;
		r.x_start  = coord_t'(rand_coord());
		r.y_start  = coord_t'(rand_coord());
		r.x_end    = coord_t'(rand_coord());
		r.y_end    = coord_t'(rand_coord());
		pend_reqs.push_back(r);
	endtask

	// driver: bursts of random length separated by random gaps
	int gap_left   = 0;
	int burst_left = 1;

	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left > 0 || pend_reqs.size() == 0) begin
				req_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				req       <= pend_reqs.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off to back the block up
	stall_mode_t smode     = STALL_NONE;
	int          mode_left = 0;
	int          hold_cnt  = 0;
	bit          hold_done = 0;
	int          rcyc      = 0;

	always @(negedge clk) begin
		rcyc++;
		if (hold_cnt > 0) begin
			res_stall <= 1'b1;
			hold_cnt--;
		end else if (!hold_done && res_seen >= 400) begin
			hold_done = 1;
			hold_cnt  = HOLD_LEN - 1;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				smode     = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (smode)
				STALL_NONE:     res_stall <= 1'b0;
				STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: res_stall <= ((rcyc % 5) < 2);
				default:        res_stall <= 1'b0;
			endcase
		end
	end

	// monitor: predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		lr_res_t e;
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				pixel_q.push_back(raster_step(req));
			if (res_valid && !res_stall) begin
				res_seen++;
				if (pixel_q.size() == 0) begin
					$error("unexpected result transaction: x=%0d y=%0d", res.pixel_x, res.pixel_y);
					errs++;
				end else begin
					e = pixel_q.pop_front();
					if (res.pixel_x !== e.pixel_x) begin
						$error("pixel_x: expected %0d, got %0d", e.pixel_x, res.pixel_x);
						errs++;
					end
					if (res.pixel_y !== e.pixel_y) begin
						$error("pixel_y: expected %0d, got %0d", e.pixel_y, res.pixel_y);
						errs++;
					end
					if (res.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, res.last);
						errs++;
					end
					if (res.valid_res !== e.valid_res) begin
						$error("valid_res: expected %0d, got %0d", e.valid_res, res.valid_res);
						errs++;
					end
				end
			end
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int bx, by, ex, ey, dx, dy, mag, span, nnext, pick;

		// directed: idle next, extremes, octants, degenerate lines, restart
		queue_next();
		queue_start(CMIN, CMIN, CMAX, CMAX);
		queue_next();
		queue_next();
		queue_start(CMAX, CMIN, CMIN, CMAX);
		queue_next();
		queue_start(3, 0, 0, 1);
		repeat (4) queue_next();
		queue_start(0, 0, 1, -3);
		repeat (3) queue_next();
		queue_start(-5, 2, -5, 2);
		queue_next();
		queue_start(CMAX, CMIN, CMAX, CMIN);
		queue_start(0, 0, 2, 5);
		queue_next();
		queue_start(CMIN, CMAX, CMIN + 3, CMAX);
		repeat (3) queue_next();

		// random: mostly complete lines, some cut short, overrun, or stray requests
		while (pend_reqs.size() < N_ITEMS) begin
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 1))
					queue_next();
				else
					queue_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end else begin
				bx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? CMIN : CMAX) : rand_coord();
				by = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? CMIN : CMAX) : rand_coord();
				pick = $urandom_range(0, 99);
				mag  = (pick < 70) ? 8 : ((pick < 97) ? 64 : 500);
				dx   = int'($urandom_range(0, 2 * mag)) - mag;
				dy   = int'($urandom_range(0, 2 * mag)) - mag;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					dy = 0;
				else if (pick == 1)
					dx = 0;
				else if (pick == 2)
					dy = $urandom_range(0, 1) ? dx : -dx;
				ex = clip_coord(bx + dx);
				ey = clip_coord(by + dy);
				queue_start(bx, by, ex, ey);
				span  = (iabs(ex - bx) > iabs(ey - by)) ? iabs(ex - bx) : iabs(ey - by);
				nnext = span;
				pick  = $urandom_range(0, 99);
				if (pick < 12 && span > 1)
					nnext = $urandom_range(0, span - 1);
				else if (pick < 22)
					nnext = span + $urandom_range(1, 2);
				repeat (nnext) queue_next();
			end
		end
		// a long final line may overshoot; cut it short
		while (pend_reqs.size() > N_ITEMS)
			void'(pend_reqs.pop_back());

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_reqs.size() != 0 || req_valid || pixel_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errs == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
